// ===== sv/dfs_adjacency_matrix_walk_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the depth-first walk block
// Concurrent checks on the block clock; empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef DFS_ADJACENCY_MATRIX_WALK_DEFINES_SVH
`define DFS_ADJACENCY_MATRIX_WALK_DEFINES_SVH

`ifndef SYNTHESIS
`define DFS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dfs walk check failed");
`define DFS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dfs walk check failed");
`else
`define DFS_ASSERT(label, prop)
`define DFS_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== sv/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared widths, command codes and the result type of the neighbor picker.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

  localparam int VERTEX_W = 6;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_WALK = 1'b1;

  typedef struct packed {
    logic                found;
    logic [VERTEX_W-1:0] index;
  } pick_result_t;

endpackage

`default_nettype wire

// ===== sv/dfs_in_if.sv =====
// ----------------------------------------------------------------------------
// dfs_in_if
// Input channel: edge and walk commands with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfs_in_if
  import dfs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [VERTEX_W-1:0] edge_from;
  logic [VERTEX_W-1:0] edge_to;
  logic [VERTEX_W-1:0] start_vertex;

  modport source (output valid, cmd, edge_from, edge_to, start_vertex, input ready);
  modport sink   (input valid, cmd, edge_from, edge_to, start_vertex, output ready);
endinterface

`default_nettype wire

// ===== sv/dfs_out_if.sv =====
// ----------------------------------------------------------------------------
// dfs_out_if
// Output channel: visited vertices in visit order with a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfs_out_if
  import dfs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] visited_vertex;
  logic                last;

  modport source (output valid, visited_vertex, last, input ready);
  modport sink   (input valid, visited_vertex, last, output ready);
endinterface

`default_nettype wire

// ===== sv/dfs_ram.sv =====
// ----------------------------------------------------------------------------
// dfs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/dfs_pick.sv =====
// ----------------------------------------------------------------------------
// dfs_pick
// Neighbor picker: lowest unvisited, in-range neighbor of one matrix row.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_pick
  import dfs_pkg::*;
#(
  parameter int ROW_W = 32
) (
  input  wire logic [ROW_W-1:0] row,
  input  wire logic [ROW_W-1:0] visited,
  input  wire logic [ROW_W-1:0] in_use,
  output      pick_result_t     result
);

  logic [ROW_W-1:0] cand;
  logic [ROW_W-1:0] lowest;

  // Two's complement trick isolates the lowest set bit; encoding a one-hot
  // word is then an OR over independent bits.
  assign cand   = row & ~visited & in_use;
  assign lowest = cand & (~cand + ROW_W'(1));

  always_comb begin
    result.found = |cand;
    result.index = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (lowest[i]) begin
        result.index = result.index | VERTEX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/dfs_adjacency_matrix_walk.sv =====
// ----------------------------------------------------------------------------
// dfs_adjacency_matrix_walk
// Depth-first walk over an undirected graph held as an adjacency bit matrix.
// ----------------------------------------------------------------------------
// An edge command updates the two matrix rows by read-modify-write through
// the single RAM write port. In a walk that visits k vertices, every stack
// step (push or pop, 2*k - 1 of them) costs one adjacency row read plus one
// pass of the neighbor picker, and the last vertex is sent once the stack
// runs empty. A walk from an out-of-range root ends in its transfer cycle.
// The matrix is clear after reset through per-row valid bits, so there is no
// clearing pass. Input is not taken while an edge or walk is in progress;
// one finished vertex can wait in the output register while the walk keeps
// popping, but the next push waits until the register is free.
`default_nettype none
`include "dfs_adjacency_matrix_walk_defines.svh"

module dfs_adjacency_matrix_walk
  import dfs_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [VERTEX_W-1:0] cfg_wr_data,
  dfs_in_if.sink                   in_ch,
  dfs_out_if.source                out_ch
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam logic [VERTEX_W:0]     MAX_N   = (VERTEX_W + 1)'(MAX_VERTICES);
  localparam logic [DW-1:0]         MAX_D   = DW'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_EDGE_RD   = 7'b0000010,
    S_EDGE_WR_A = 7'b0000100,
    S_EDGE_WR_B = 7'b0001000,
    S_ROW       = 7'b0010000,
    S_EVAL      = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [VERTEX_W-1:0]     num_vertices;
  logic [VERTEX_W:0]       n_use;
  logic [MAX_VERTICES-1:0] in_use;
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] visited;
  logic [VW-1:0]           top;
  logic [DW-1:0]           depth;
  logic [VW-1:0]           ea, eb;
  logic [VERTEX_W-1:0]     pend_vertex;

  logic                    out_valid;
  logic [VERTEX_W-1:0]     out_vertex;
  logic                    out_last;
  logic                    out_free;

  logic [VERTEX_W-1:0]     from_m1, to_m1, root_m1;
  logic                    from_ok, to_ok, root_ok;
  logic                    accept;

  logic                    adj_wr_en;
  logic [VW-1:0]           adj_wr_addr;
  logic [MAX_VERTICES-1:0] adj_wr_data;
  logic [VW-1:0]           adj_rd_addr;
  logic [MAX_VERTICES-1:0] adj_rd_data;
  logic                    adj_rd_valid;
  logic [MAX_VERTICES-1:0] adj_row;

  logic                    stk_wr_en;
  logic [VW-1:0]           stk_wr_addr;
  logic [VW-1:0]           stk_rd_addr;
  logic [VW-1:0]           stk_rd_data;
  logic [DW-1:0]           depth_m1, depth_m2;

  pick_result_t            pick;
  logic [VW-1:0]           nb_idx;
  logic                    push;
  logic                    emit;
  logic                    emit_last;

  assign n_use = ((VERTEX_W + 1)'(num_vertices) > MAX_N) ? MAX_N
                                                         : (VERTEX_W + 1)'(num_vertices);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      in_use[i] = ((VERTEX_W + 1)'(i) < n_use);
    end
  end

  assign from_m1 = in_ch.edge_from - VERTEX_W'(1);
  assign to_m1   = in_ch.edge_to - VERTEX_W'(1);
  assign root_m1 = in_ch.start_vertex - VERTEX_W'(1);
  assign from_ok = (in_ch.edge_from != '0) && ((VERTEX_W + 1)'(in_ch.edge_from) <= n_use);
  assign to_ok   = (in_ch.edge_to != '0) && ((VERTEX_W + 1)'(in_ch.edge_to) <= n_use);
  assign root_ok = (in_ch.start_vertex != '0)
                   && ((VERTEX_W + 1)'(in_ch.start_vertex) <= n_use);

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_free = !out_valid || out_ch.ready;

  assign depth_m1    = depth - DW'(1);
  assign depth_m2    = depth - DW'(2);
  assign stk_wr_addr = depth_m1[VW-1:0];
  assign stk_rd_addr = depth_m2[VW-1:0];

  assign adj_row = adj_rd_valid ? adj_rd_data : '0;
  assign nb_idx  = pick.index[VW-1:0];

  dfs_pick #(
    .ROW_W (MAX_VERTICES)
  ) u_pick (
    .row     (adj_row),
    .visited (visited),
    .in_use  (in_use),
    .result  (pick)
  );

  dfs_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  dfs_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (top),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  always_comb begin
    state_next  = state;
    adj_wr_en   = 1'b0;
    adj_wr_addr = ea;
    adj_wr_data = adj_row | (ROW_ONE << eb);
    adj_rd_addr = top;
    stk_wr_en   = 1'b0;
    push        = 1'b0;
    emit        = 1'b0;
    emit_last   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.cmd == CMD_EDGE) begin
            if (from_ok && to_ok) begin
              state_next = S_EDGE_RD;
            end
          end else if (root_ok) begin
            state_next = S_ROW;
          end
        end
      end
      S_EDGE_RD: begin
        adj_rd_addr = ea;
        state_next  = S_EDGE_WR_A;
      end
      S_EDGE_WR_A: begin
        // Row b is read while row a is written; for a self loop both hold
        // the same bit, so the stale read loses nothing.
        adj_wr_en   = 1'b1;
        adj_rd_addr = eb;
        state_next  = S_EDGE_WR_B;
      end
      S_EDGE_WR_B: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = eb;
        adj_wr_data = adj_row | (ROW_ONE << ea);
        state_next  = S_IDLE;
      end
      S_ROW: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (pick.found && (depth < MAX_D)) begin
          // The pending vertex leaves only when the next one is known, so the
          // final vertex of the walk can carry the last flag.
          if (out_free) begin
            push       = 1'b1;
            emit       = 1'b1;
            stk_wr_en  = 1'b1;
            state_next = S_ROW;
          end
        end else if (depth == DW'(1)) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_ROW;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      num_vertices <= VERTEX_W'(32);
      row_valid    <= '0;
      depth        <= '0;
      out_valid    <= 1'b0;
      visited      <= '0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        num_vertices <= cfg_wr_data;
      end

      if (adj_wr_en) begin
        row_valid[adj_wr_addr] <= 1'b1;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (accept && (in_ch.cmd == CMD_WALK) && root_ok) begin
        visited <= ROW_ONE << root_m1[VW-1:0];
        depth   <= DW'(1);
      end else if (push) begin
        visited <= visited | (ROW_ONE << nb_idx);
        depth   <= depth + DW'(1);
      end else if ((state == S_EVAL) && !(pick.found && (depth < MAX_D))) begin
        depth <= depth_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    adj_rd_valid <= row_valid[adj_rd_addr];

    if (accept) begin
      ea          <= from_m1[VW-1:0];
      eb          <= to_m1[VW-1:0];
      top         <= root_m1[VW-1:0];
      pend_vertex <= in_ch.start_vertex;
    end else if (push) begin
      top         <= nb_idx;
      pend_vertex <= VERTEX_W'(nb_idx) + VERTEX_W'(1);
    end else if ((state == S_EVAL) && !(pick.found && (depth < MAX_D))) begin
      top <= stk_rd_data;
    end

    if (emit) begin
      out_vertex <= pend_vertex;
      out_last   <= emit_last;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.visited_vertex = out_vertex;
  assign out_ch.last           = out_last;

  `DFS_ASSERT(a_depth_bound, depth <= MAX_D)
  `DFS_ASSERT(a_walk_top_visited,
              (state == S_ROW || state == S_EVAL) |-> (visited[top] && depth != '0))
  `DFS_ASSERT(a_push_unvisited, push |-> !visited[nb_idx])
  `DFS_ASSERT(a_last_ends_walk, (emit && emit_last) |=> (state == S_IDLE && depth == '0))

endmodule

`default_nettype wire
